// ===== rtl/core/line_follow_drive_step_core_assert.svh =====
// Assertion macros shared by the line follower drive step RTL.
`ifndef LINE_FOLLOW_DRIVE_STEP_CORE_ASSERT_SVH
`define LINE_FOLLOW_DRIVE_STEP_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LFDS_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LFDS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lfds_pkg.sv =====
// Package with types, constants and helper functions of the line follower drive step.
`timescale 1ns / 1ps

package lfds_pkg;

   localparam int DutyW = 10;
   localparam int PosW = 5;
   localparam int CsrAddrW = 3;
   localparam int MulW = 11;
   localparam int ProdW = 2 * MulW;
   localparam int SumW = 16;

   localparam logic [DutyW-1:0] DutyMax = 10'd1023;

   // Register indexes of the configuration port.
   localparam logic [CsrAddrW-1:0] CSR_STEER_GAIN   = 3'd0;
   localparam logic [CsrAddrW-1:0] CSR_STEER_MULT   = 3'd1;
   localparam logic [CsrAddrW-1:0] CSR_BRAKE_START  = 3'd2;
   localparam logic [CsrAddrW-1:0] CSR_BRAKE_STOP   = 3'd3;
   localparam logic [CsrAddrW-1:0] CSR_CRUISE_SPEED = 3'd4;
   localparam logic [CsrAddrW-1:0] CSR_BRAKE_FLOOR  = 3'd5;
   localparam logic [CsrAddrW-1:0] CSR_RECOVER_FAST = 3'd6;
   localparam logic [CsrAddrW-1:0] CSR_RECOVER_SLOW = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [5:0]       RstSteerGain   = 6'd15;
   localparam logic [2:0]       RstSteerMult   = 3'd1;
   localparam logic [DutyW-1:0] RstBrakeStart  = 10'd350;
   localparam logic [DutyW-1:0] RstBrakeStop   = 10'd550;
   localparam logic [DutyW-1:0] RstCruiseSpeed = 10'd330;
   localparam logic [DutyW-1:0] RstBrakeFloor  = 10'd100;
   localparam logic [DutyW-1:0] RstRecoverFast = 10'd260;
   localparam logic [DutyW-1:0] RstRecoverSlow = 10'd80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BRAKE_MUL,
      ST_BRAKE_DIV,
      ST_GAIN_MUL,
      ST_STEER_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                   known;
      logic signed [PosW-1:0] pos;
   } pos_lookup_type;

   // Maps a sensor pattern to a line position; unknown patterns clear known.
   function automatic pos_lookup_type lookup_position(input logic [7:0] pattern);
      pos_lookup_type res;
      res.known = 1'b1;
      case (pattern)
         8'h01: res.pos = 5'sd12;
         8'h03: res.pos = 5'sd10;
         8'h02: res.pos = 5'sd9;
         8'h06: res.pos = 5'sd7;
         8'h04: res.pos = 5'sd5;
         8'h0C: res.pos = 5'sd3;
         8'h08: res.pos = 5'sd2;
         8'h18: res.pos = 5'sd0;
         8'h10: res.pos = -5'sd2;
         8'h30: res.pos = -5'sd3;
         8'h20: res.pos = -5'sd5;
         8'h60: res.pos = -5'sd7;
         8'h40: res.pos = -5'sd9;
         8'hC0: res.pos = -5'sd10;
         8'h80: res.pos = -5'sd12;
         default: begin
            res.known = 1'b0;
            res.pos = 5'sd0;
         end
      endcase
      return res;
   endfunction

   // Clamps a signed duty sum to the PWM range.
   function automatic logic [DutyW-1:0] sat_duty(input logic signed [SumW-1:0] v);
      logic [DutyW-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({{(SumW-DutyW){1'b0}}, DutyMax})) begin
         res = DutyMax;
      end else begin
         res = v[DutyW-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/line_follow_drive_step_core.sv =====
// Line follower drive step: one request of sensor readings in, one pair of motor duties out.
// A known pattern steps through BRAKE_MUL, BRAKE_DIV, GAIN_MUL, STEER_MUL and DONE to the
// response register, a line loss straight to DONE. One request is in work at a time,
// paced by the single shared multiplier and its sequencer; a stalled response holds off the
// next request. Reset (synchronous, active high) loads the register defaults, clears the
// stored last position and empties the sequencer and the response register.
`timescale 1ns / 1ps

`include "line_follow_drive_step_core_assert.svh"

module line_follow_drive_step_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_line_pattern,
   input  logic [lfds_pkg::DutyW-1:0]           req_dist_left,
   input  logic [lfds_pkg::DutyW-1:0]           req_dist_right,
   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lfds_pkg::DutyW-1:0]           rsp_duty_left,
   output logic [lfds_pkg::DutyW-1:0]           rsp_duty_right,
   output logic                                 rsp_line_lost,
   output logic                                 rsp_obstacle_stop,
   // Configuration write port.
   input  logic                                 csr_wr_en,
   input  logic [lfds_pkg::CsrAddrW-1:0]        csr_addr,
   input  logic [lfds_pkg::DutyW-1:0]           csr_wdata
);

   // Configuration registers.
   logic [5:0]                      steer_gain_ff;
   logic [2:0]                      steer_mult_ff;
   logic [lfds_pkg::DutyW-1:0]      brake_start_ff;
   logic [lfds_pkg::DutyW-1:0]      brake_stop_ff;
   logic [lfds_pkg::DutyW-1:0]      cruise_speed_ff;
   logic [lfds_pkg::DutyW-1:0]      brake_floor_ff;
   logic [lfds_pkg::DutyW-1:0]      recover_fast_ff;
   logic [lfds_pkg::DutyW-1:0]      recover_slow_ff;

   // Sequencer and working registers.
   lfds_pkg::state_type                  state_ff, state_in;
   logic signed [lfds_pkg::PosW-1:0]     pos_ff, pos_in;
   logic                                 lost_ff, lost_in;
   logic [lfds_pkg::DutyW-1:0]           s_ff, s_in;
   logic signed [lfds_pkg::ProdW-1:0]    acc_ff, acc_in;
   logic [lfds_pkg::DutyW-1:0]           base_ff, base_in;
   logic signed [lfds_pkg::PosW-1:0]     last_position_ff, last_position_in;

   // Response register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [lfds_pkg::DutyW-1:0]           rsp_duty_left_ff, rsp_duty_left_in;
   logic [lfds_pkg::DutyW-1:0]           rsp_duty_right_ff, rsp_duty_right_in;
   logic                                 rsp_line_lost_ff, rsp_line_lost_in;
   logic                                 rsp_obstacle_stop_ff, rsp_obstacle_stop_in;

   // Shared multiplier and its operand selection.
   logic signed [lfds_pkg::MulW-1:0]     mul_a;
   logic signed [lfds_pkg::MulW-1:0]     mul_b;
   logic signed [lfds_pkg::ProdW-1:0]    mul_p;

   // Datapath helpers.
   lfds_pkg::pos_lookup_type             lookup;
   logic [lfds_pkg::DutyW-1:0]           quot_lo;
   logic [lfds_pkg::DutyW:0]             quot_rem;
   logic [lfds_pkg::DutyW-1:0]           quot;
   logic signed [lfds_pkg::SumW-1:0]     base_ext;
   logic signed [lfds_pkg::SumW-1:0]     delta;
   logic signed [lfds_pkg::SumW-1:0]     sum_left;
   logic signed [lfds_pkg::SumW-1:0]     sum_right;
   logic                                 out_free;

   assign req_stall         = (state_ff != lfds_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty_left     = rsp_duty_left_ff;
   assign rsp_duty_right    = rsp_duty_right_ff;
   assign rsp_line_lost     = rsp_line_lost_ff;
   assign rsp_obstacle_stop = rsp_obstacle_stop_ff;

   assign mul_p = mul_a * mul_b;
   assign lookup = lfds_pkg::lookup_position(req_line_pattern);

   // The product (1023 - s) * cruise is below 2^20. Dividing by 1023: with q0 = x >> 10,
   // the remainder x - 1023 * q0 equals the low ten bits plus q0, which stays below
   // twice 1023, so one compare and increment gives the truncated quotient.
   assign quot_lo  = acc_ff[2*lfds_pkg::DutyW-1:lfds_pkg::DutyW];
   assign quot_rem = {1'b0, acc_ff[lfds_pkg::DutyW-1:0]} + {1'b0, quot_lo};
   assign quot     = (quot_rem >= {1'b0, lfds_pkg::DutyMax}) ? quot_lo + 1'b1 : quot_lo;

   // Steering sums, formed once the steering correction sits in the accumulator.
   assign base_ext  = signed'({{(lfds_pkg::SumW-lfds_pkg::DutyW){1'b0}}, base_ff});
   assign delta     = acc_ff[lfds_pkg::SumW-1:0];
   assign sum_left  = base_ext + delta;
   assign sum_right = base_ext - delta;

   // The response register can take a new response when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in             = state_ff;
      pos_in               = pos_ff;
      lost_in              = lost_ff;
      s_in                 = s_ff;
      acc_in               = acc_ff;
      base_in              = base_ff;
      last_position_in     = last_position_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_duty_left_in     = rsp_duty_left_ff;
      rsp_duty_right_in    = rsp_duty_right_ff;
      rsp_line_lost_in     = rsp_line_lost_ff;
      rsp_obstacle_stop_in = rsp_obstacle_stop_ff;
      mul_a                = '0;
      mul_b                = '0;

      case (state_ff)
         lfds_pkg::ST_IDLE: begin
            // Capture the request: decode the pattern and keep the nearer obstacle reading.
            if (req_valid) begin
               pos_in   = lookup.pos;
               lost_in  = !lookup.known;
               s_in     = (req_dist_left > req_dist_right) ? req_dist_left : req_dist_right;
               state_in = lookup.known ? lfds_pkg::ST_BRAKE_MUL : lfds_pkg::ST_DONE;
            end
         end
         lfds_pkg::ST_BRAKE_MUL: begin
            // For a ten-bit reading, 1023 - s is the bitwise complement.
            mul_a    = signed'({1'b0, ~s_ff});
            mul_b    = signed'({1'b0, cruise_speed_ff});
            acc_in   = mul_p;
            state_in = lfds_pkg::ST_BRAKE_DIV;
         end
         lfds_pkg::ST_BRAKE_DIV: begin
            if (s_ff > brake_start_ff) begin
               if (s_ff > brake_stop_ff) begin
                  base_in = '0;
               end else if (quot < brake_floor_ff) begin
                  base_in = brake_floor_ff;
               end else begin
                  base_in = quot;
               end
            end else begin
               base_in = cruise_speed_ff;
            end
            state_in = lfds_pkg::ST_GAIN_MUL;
         end
         lfds_pkg::ST_GAIN_MUL: begin
            mul_a    = signed'({{(lfds_pkg::MulW-3){1'b0}}, steer_mult_ff});
            mul_b    = signed'({{(lfds_pkg::MulW-6){1'b0}}, steer_gain_ff});
            acc_in   = mul_p;
            state_in = lfds_pkg::ST_STEER_MUL;
         end
         lfds_pkg::ST_STEER_MUL: begin
            // Gain product is at most 441 and fits the signed operand width.
            mul_a    = acc_ff[lfds_pkg::MulW-1:0];
            mul_b    = {{(lfds_pkg::MulW-lfds_pkg::PosW){pos_ff[lfds_pkg::PosW-1]}}, pos_ff};
            acc_in   = mul_p;
            state_in = lfds_pkg::ST_DONE;
         end
         lfds_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = lfds_pkg::ST_IDLE;
               if (lost_ff) begin
                  // Line loss: turn toward the side where the line was last seen.
                  rsp_line_lost_in     = 1'b1;
                  rsp_obstacle_stop_in = 1'b0;
                  if (last_position_ff[lfds_pkg::PosW-1]) begin
                     rsp_duty_left_in  = recover_slow_ff;
                     rsp_duty_right_in = recover_fast_ff;
                  end else begin
                     rsp_duty_left_in  = recover_fast_ff;
                     rsp_duty_right_in = recover_slow_ff;
                  end
               end else if (base_ff == '0) begin
                  rsp_line_lost_in     = 1'b0;
                  rsp_obstacle_stop_in = 1'b1;
                  rsp_duty_left_in     = '0;
                  rsp_duty_right_in    = '0;
               end else begin
                  rsp_line_lost_in     = 1'b0;
                  rsp_obstacle_stop_in = 1'b0;
                  rsp_duty_left_in     = lfds_pkg::sat_duty(sum_left);
                  rsp_duty_right_in    = lfds_pkg::sat_duty(sum_right);
                  last_position_in     = pos_ff;
               end
            end
         end
         default: begin
            state_in = lfds_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= lfds_pkg::ST_IDLE;
         last_position_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         last_position_ff <= last_position_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff               <= pos_in;
      lost_ff              <= lost_in;
      s_ff                 <= s_in;
      acc_ff               <= acc_in;
      base_ff              <= base_in;
      rsp_duty_left_ff     <= rsp_duty_left_in;
      rsp_duty_right_ff    <= rsp_duty_right_in;
      rsp_line_lost_ff     <= rsp_line_lost_in;
      rsp_obstacle_stop_ff <= rsp_obstacle_stop_in;
   end

   // Configuration writes; the index covers exactly the eight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         steer_gain_ff   <= lfds_pkg::RstSteerGain;
         steer_mult_ff   <= lfds_pkg::RstSteerMult;
         brake_start_ff  <= lfds_pkg::RstBrakeStart;
         brake_stop_ff   <= lfds_pkg::RstBrakeStop;
         cruise_speed_ff <= lfds_pkg::RstCruiseSpeed;
         brake_floor_ff  <= lfds_pkg::RstBrakeFloor;
         recover_fast_ff <= lfds_pkg::RstRecoverFast;
         recover_slow_ff <= lfds_pkg::RstRecoverSlow;
      end else if (csr_wr_en) begin
         case (csr_addr)
            lfds_pkg::CSR_STEER_GAIN:   steer_gain_ff   <= csr_wdata[5:0];
            lfds_pkg::CSR_STEER_MULT:   steer_mult_ff   <= csr_wdata[2:0];
            lfds_pkg::CSR_BRAKE_START:  brake_start_ff  <= csr_wdata;
            lfds_pkg::CSR_BRAKE_STOP:   brake_stop_ff   <= csr_wdata;
            lfds_pkg::CSR_CRUISE_SPEED: cruise_speed_ff <= csr_wdata;
            lfds_pkg::CSR_BRAKE_FLOOR:  brake_floor_ff  <= csr_wdata;
            lfds_pkg::CSR_RECOVER_FAST: recover_fast_ff <= csr_wdata;
            lfds_pkg::CSR_RECOVER_SLOW: recover_slow_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // An accepted request keeps the sequencer busy in the following cycle.
   `LFDS_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall,
      state_ff != lfds_pkg::ST_IDLE, "sequencer idle after accepting a request")
   // A response never reports line loss and an obstacle stop together.
   `LFDS_ASSERT_SAME(a_flags_exclusive, rsp_valid, !(rsp_line_lost && rsp_obstacle_stop),
      "line loss and obstacle stop both set")
   // An obstacle stop drives both motors to zero.
   `LFDS_ASSERT_SAME(a_stop_zero, rsp_valid && rsp_obstacle_stop,
      rsp_duty_left == '0 && rsp_duty_right == '0, "obstacle stop with nonzero duty")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the line follower drive step core.
`timescale 1ns / 1ps

module tb;

   localparam int HalfPeriod    = 4;
   localparam int IdlePercent   = 23;
   localparam int HoldOffCycles = 150;
   localparam int QuietLimit    = 5000;
   localparam int DrainCycles   = 12;

   // One motor command as the block reports it.
   typedef struct packed {
      logic [lfds_pkg::DutyW-1:0] duty_left;
      logic [lfds_pkg::DutyW-1:0] duty_right;
      logic                       line_lost;
      logic                       obstacle_stop;
   } drive_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_line_pattern = '0;
   logic [lfds_pkg::DutyW-1:0]    req_dist_left = '0;
   logic [lfds_pkg::DutyW-1:0]    req_dist_right = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [lfds_pkg::DutyW-1:0]    rsp_duty_left;
   logic [lfds_pkg::DutyW-1:0]    rsp_duty_right;
   logic                          rsp_line_lost;
   logic                          rsp_obstacle_stop;
   logic                          csr_wr_en = 1'b0;
   logic [lfds_pkg::CsrAddrW-1:0] csr_addr = '0;
   logic [lfds_pkg::DutyW-1:0]    csr_wdata = '0;

   // Our own copy of the control registers and of the remembered line position.
   logic [5:0]                       drive_gain = lfds_pkg::RstSteerGain;
   logic [2:0]                       drive_mult = lfds_pkg::RstSteerMult;
   logic [lfds_pkg::DutyW-1:0]       drive_brake_start = lfds_pkg::RstBrakeStart;
   logic [lfds_pkg::DutyW-1:0]       drive_brake_stop = lfds_pkg::RstBrakeStop;
   logic [lfds_pkg::DutyW-1:0]       drive_cruise = lfds_pkg::RstCruiseSpeed;
   logic [lfds_pkg::DutyW-1:0]       drive_floor = lfds_pkg::RstBrakeFloor;
   logic [lfds_pkg::DutyW-1:0]       drive_fast = lfds_pkg::RstRecoverFast;
   logic [lfds_pkg::DutyW-1:0]       drive_slow = lfds_pkg::RstRecoverSlow;
   logic signed [lfds_pkg::PosW-1:0] heading_pos = '0;

   // Commands predicted for accepted requests, oldest first.
   drive_result_type expected_drive_q[$];

   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int lost_seen = 0;
   int stops_seen = 0;
   int settings_used = 0;
   int quiet_cycles = 0;
   int holdoff_left = 0;
   bit sender_idle_on = 1'b1;
   bit receiver_idle_on = 1'b1;
   bit holdoff_request = 1'b0;

   line_follow_drive_step_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_line_pattern  (req_line_pattern),
      .req_dist_left     (req_dist_left),
      .req_dist_right    (req_dist_right),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_duty_left     (rsp_duty_left),
      .rsp_duty_right    (rsp_duty_right),
      .rsp_line_lost     (rsp_line_lost),
      .rsp_obstacle_stop (rsp_obstacle_stop),
      .csr_wr_en         (csr_wr_en),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   always #(HalfPeriod) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // Decodes a sensor pattern into a signed line offset. Only a single lit sensor or two
   // adjacent lit sensors describe a line; anything else means the line is lost.
   function automatic bit line_offset(input logic [7:0] pattern, output int offset);
      offset = 0;
      case (pattern)
         8'h01: offset = 12;
         8'h03: offset = 10;
         8'h02: offset = 9;
         8'h06: offset = 7;
         8'h04: offset = 5;
         8'h0C: offset = 3;
         8'h08: offset = 2;
         8'h18: offset = 0;
         8'h10: offset = -2;
         8'h30: offset = -3;
         8'h20: offset = -5;
         8'h60: offset = -7;
         8'h40: offset = -9;
         8'hC0: offset = -10;
         8'h80: offset = -12;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic [lfds_pkg::DutyW-1:0] clamp_duty(input int v);
      if (v < 0) return '0;
      if (v > int'(lfds_pkg::DutyMax)) return lfds_pkg::DutyMax;
      return v[lfds_pkg::DutyW-1:0];
   endfunction

   // Works out the motor command for one request and advances the remembered position.
   function automatic drive_result_type predict_drive(input logic [7:0] pattern,
                                                      input logic [lfds_pkg::DutyW-1:0] dist_l,
                                                      input logic [lfds_pkg::DutyW-1:0] dist_r);
      drive_result_type res;
      int offset;
      int nearest;
      int base;
      int gain_i;
      int mult_i;
      int delta;
      res = '0;
      // Line loss is handled before braking: spin toward the side the line was last seen.
      if (!line_offset(pattern, offset)) begin
         res.line_lost = 1'b1;
         if (heading_pos < 0) begin
            res.duty_left = drive_slow;
            res.duty_right = drive_fast;
         end else begin
            res.duty_left = drive_fast;
            res.duty_right = drive_slow;
         end
         return res;
      end
      // The closer of the two obstacles decides the base speed.
      nearest = (dist_l > dist_r) ? int'(dist_l) : int'(dist_r);
      if (nearest > int'(drive_brake_start)) begin
         base = ((int'(lfds_pkg::DutyMax) - nearest) * int'(drive_cruise))
                / int'(lfds_pkg::DutyMax);
         if (nearest > int'(drive_brake_stop)) begin
            base = 0;
         end else if (base < int'(drive_floor)) begin
            base = int'(drive_floor);
         end
      end else begin
         base = int'(drive_cruise);
      end
      if (base == 0) begin
         res.obstacle_stop = 1'b1;
         return res;
      end
      gain_i = int'(drive_gain);
      mult_i = int'(drive_mult);
      delta = mult_i * gain_i * offset;
      res.duty_left = clamp_duty(base + delta);
      res.duty_right = clamp_duty(base - delta);
      heading_pos = offset[lfds_pkg::PosW-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   task automatic flag_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Every accepted response is compared with the oldest outstanding prediction.
   always @(posedge clock) begin : check_response
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drive_q.size() == 0) begin
            $display("%0t: response with nothing outstanding, left %0d right %0d lost %0b stop %0b",
                     $time, rsp_duty_left, rsp_duty_right, rsp_line_lost, rsp_obstacle_stop);
            error_count++;
         end else begin
            want = expected_drive_q.pop_front();
            responses_checked++;
            if (want.line_lost) lost_seen++;
            if (want.obstacle_stop) stops_seen++;
            flag_field("duty_left", int'(want.duty_left), int'(rsp_duty_left));
            flag_field("duty_right", int'(want.duty_right), int'(rsp_duty_right));
            flag_field("line_lost", int'(want.line_lost), int'(rsp_line_lost));
            flag_field("obstacle_stop", int'(want.obstacle_stop), int'(rsp_obstacle_stop));
         end
      end
   end

   // A run that stops moving is a failure: count cycles in which no handshake completes.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no handshake for %0d cycles, %0d responses still outstanding",
                  $time, quiet_cycles, expected_drive_q.size());
         $display("FAIL line_follow_drive_step_core");
         $finish;
      end
   end

   // Response side. A requested hold-off keeps the block blocked for a long, self-counted
   // stretch; otherwise the stall is random or off.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall = 1'b1;
         holdoff_left--;
      end else if (holdoff_request) begin
         holdoff_request = 1'b0;
         holdoff_left = HoldOffCycles - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = receiver_idle_on && ($urandom_range(99) < IdlePercent);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers. All of them start and end at a falling clock edge.
   // ---------------------------------------------------------------------------------------

   // Offers one request, waits until the block takes it, then records the prediction.
   task automatic send_request(input logic [7:0] pattern,
                               input logic [lfds_pkg::DutyW-1:0] dist_l,
                               input logic [lfds_pkg::DutyW-1:0] dist_r);
      while (sender_idle_on && $urandom_range(99) < IdlePercent) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_line_pattern = pattern;
      req_dist_left = dist_l;
      req_dist_right = dist_r;
      do @(posedge clock); while (req_stall);
      expected_drive_q.push_back(predict_drive(pattern, dist_l, dist_r));
      requests_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_until_drained();
      while (expected_drive_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [lfds_pkg::CsrAddrW-1:0] index,
                                 input logic [lfds_pkg::DutyW-1:0] value);
      csr_wr_en = 1'b1;
      csr_addr = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      // Narrow registers keep only their low bits.
      case (index)
         lfds_pkg::CSR_STEER_GAIN:   drive_gain = value[5:0];
         lfds_pkg::CSR_STEER_MULT:   drive_mult = value[2:0];
         lfds_pkg::CSR_BRAKE_START:  drive_brake_start = value;
         lfds_pkg::CSR_BRAKE_STOP:   drive_brake_stop = value;
         lfds_pkg::CSR_CRUISE_SPEED: drive_cruise = value;
         lfds_pkg::CSR_BRAKE_FLOOR:  drive_floor = value;
         lfds_pkg::CSR_RECOVER_FAST: drive_fast = value;
         lfds_pkg::CSR_RECOVER_SLOW: drive_slow = value;
         default: ;
      endcase
   endtask

   // Loads a full register set. Registers only change while the block has nothing in work.
   task automatic apply_setting(input logic [lfds_pkg::DutyW-1:0] gain,
                                input logic [lfds_pkg::DutyW-1:0] mult,
                                input logic [lfds_pkg::DutyW-1:0] brake_start,
                                input logic [lfds_pkg::DutyW-1:0] brake_stop,
                                input logic [lfds_pkg::DutyW-1:0] cruise,
                                input logic [lfds_pkg::DutyW-1:0] floor,
                                input logic [lfds_pkg::DutyW-1:0] fast,
                                input logic [lfds_pkg::DutyW-1:0] slow);
      wait_until_drained();
      write_register(lfds_pkg::CSR_STEER_GAIN, gain);
      write_register(lfds_pkg::CSR_STEER_MULT, mult);
      write_register(lfds_pkg::CSR_BRAKE_START, brake_start);
      write_register(lfds_pkg::CSR_BRAKE_STOP, brake_stop);
      write_register(lfds_pkg::CSR_CRUISE_SPEED, cruise);
      write_register(lfds_pkg::CSR_BRAKE_FLOOR, floor);
      write_register(lfds_pkg::CSR_RECOVER_FAST, fast);
      write_register(lfds_pkg::CSR_RECOVER_SLOW, slow);
      settings_used++;
   endtask

   // Mostly valid line shapes (one lit sensor or an adjacent pair), some arbitrary noise.
   function automatic logic [7:0] pick_pattern();
      int choice;
      int raw;
      choice = $urandom_range(9);
      if (choice < 4) return 8'h01 << $urandom_range(7);
      if (choice < 7) return 8'h03 << $urandom_range(6);
      raw = $urandom_range(255);
      return raw[7:0];
   endfunction

   // Distances either span the full range or sit right around one of the brake thresholds.
   function automatic logic [lfds_pkg::DutyW-1:0] pick_distance();
      int choice;
      int pivot;
      choice = $urandom_range(9);
      if (choice < 4) begin
         pivot = $urandom_range(1023);
         return pivot[lfds_pkg::DutyW-1:0];
      end
      pivot = (choice < 7) ? int'(drive_brake_start) : int'(drive_brake_stop);
      pivot = pivot + int'($urandom_range(6)) - 3;
      if (pivot < 0) pivot = 0;
      if (pivot > 1023) pivot = 1023;
      return pivot[lfds_pkg::DutyW-1:0];
   endfunction

   function automatic logic [lfds_pkg::DutyW-1:0] pick_level(input int top);
      int choice;
      int level;
      choice = $urandom_range(5);
      if (choice == 0) return '0;
      if (choice == 1) return top[lfds_pkg::DutyW-1:0];
      level = $urandom_range(top);
      return level[lfds_pkg::DutyW-1:0];
   endfunction

   task automatic run_random_phase(input int count);
      apply_setting(pick_level(63), pick_level(7), pick_level(1023), pick_level(1023),
                    pick_level(1023), pick_level(1023), pick_level(1023), pick_level(1023));
      repeat (count) send_request(pick_pattern(), pick_distance(), pick_distance());
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset register values: every line shape, both recovery directions, and the braking
   // regions around the start and stop thresholds.
   task automatic test_reset_behavior();
      for (int k = 0; k < 8; k++) begin
         send_request(8'h01 << k, '0, '0);
         if (k < 7) send_request(8'h03 << k, '0, '0);
      end
      // The line was last seen far to one side, so recovery turns that way.
      send_request(8'h00, '0, '0);
      // A stop must not update the remembered position.
      send_request(8'h01, 10'd1023, '0);
      send_request(8'hFF, '0, 10'd1023);
      send_request(8'h18, '0, 10'd400);
      send_request(8'h18, 10'd500, 10'd10);
      send_request(8'h18, 10'd350, 10'd350);
      send_request(8'h10, 10'd551, '0);
      send_request(8'h08, 10'd550, 10'd550);
      send_request(8'h81, '0, '0);
   endtask

   // Register extremes, a stop threshold below the start threshold, a floor above the cruise
   // speed, and writes whose upper data bits fall outside the narrow registers.
   task automatic test_register_extremes();
      apply_setting(10'd63, 10'd7, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
      send_request(8'h01, '0, '0);
      send_request(8'h80, 10'd1023, 10'd1023);
      send_request(8'h18, 10'd1023, '0);
      send_request(8'h55, '0, '0);

      apply_setting('0, '0, '0, '0, '0, '0, '0, '0);
      send_request(8'h01, '0, '0);
      send_request(8'h80, 10'd1, '0);
      send_request(8'hAA, '0, '0);

      apply_setting(10'd20, 10'd3, 10'd600, 10'd200, 10'd500, 10'd900, 10'd700, 10'd300);
      send_request(8'h40, 10'd400, '0);
      send_request(8'h02, 10'd601, '0);
      send_request(8'h0C, 10'd600, '0);

      apply_setting(10'd9, 10'd2, 10'd100, 10'd1000, 10'd400, 10'd900, 10'd5, 10'd1000);
      send_request(8'h20, 10'd500, '0);
      send_request(8'h00, '0, '0);
      send_request(8'h06, 10'd1001, '0);

      apply_setting(10'h3EA, 10'h3FD, 10'd300, 10'd700, 10'd800, 10'd150, 10'd600, 10'd200);
      send_request(8'h01, 10'd200, 10'd650);
      send_request(8'hC0, '0, '0);
   endtask

   // The receiver blocks for a long time while requests keep coming, so the block fills and
   // pushes back; afterwards the sender waits for every response before carrying on.
   task automatic test_backpressure();
      apply_setting({4'b0000, lfds_pkg::RstSteerGain}, {7'b0000000, lfds_pkg::RstSteerMult},
                    lfds_pkg::RstBrakeStart, lfds_pkg::RstBrakeStop, lfds_pkg::RstCruiseSpeed,
                    lfds_pkg::RstBrakeFloor, lfds_pkg::RstRecoverFast,
                    lfds_pkg::RstRecoverSlow);
      sender_idle_on = 1'b0;
      holdoff_request = 1'b1;
      repeat (20) send_request(pick_pattern(), pick_distance(), pick_distance());
      wait_until_drained();
      repeat (10) send_request(pick_pattern(), pick_distance(), pick_distance());
      sender_idle_on = 1'b1;
   endtask

   // Random register sets with random traffic, including one stretch at full rate on both
   // sides.
   task automatic test_random_traffic();
      repeat (4) run_random_phase(48);
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      run_random_phase(60);
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      repeat (4) run_random_phase(48);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_behavior();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      wait_until_drained();
      repeat (DrainCycles) @(negedge clock);

      $display("Drove %0d requests over %0d register sets; %0d responses checked.",
               requests_sent, settings_used, responses_checked);
      $display("Saw %0d line-loss and %0d obstacle-stop responses, plus a long hold-off.",
               lost_seen, stops_seen);
      if (error_count == 0) begin
         $display("PASS line_follow_drive_step_core");
      end else begin
         $display("FAIL line_follow_drive_step_core");
      end
      $finish;
   end

endmodule
